FILE: src/lzw_byte_compressor_unit_macros.svh
// Assertion macros for the LZW compressor.
`ifndef LZW_BYTE_COMPRESSOR_UNIT_MACROS_SVH
`define LZW_BYTE_COMPRESSOR_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define LZWC_ASSERT_ALWAYS(name, ck, rstn, expr) \
    name: assert property (@(posedge ck) disable iff (!rstn) (expr)) \
        else $error("lzwc assertion failed");

`define LZWC_ASSERT_IMPL(name, ck, rstn, ante, cons) \
    name: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("lzwc assertion failed");

`define LZWC_ASSERT_NEXT(name, ck, rstn, ante, cons) \
    name: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("lzwc assertion failed");

`else

`define LZWC_ASSERT_ALWAYS(name, ck, rstn, expr)
`define LZWC_ASSERT_IMPL(name, ck, rstn, ante, cons)
`define LZWC_ASSERT_NEXT(name, ck, rstn, ante, cons)

`endif

`endif

FILE: src/lzwc_pkg.sv
package lzwc_pkg;

    localparam int LITERAL_CODES = 256;
    localparam int OUT_CODE_W    = 12;
    localparam int EPOCH_BITS    = 6;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } byte_item_t;

    typedef struct packed {
        logic [OUT_CODE_W-1:0] out_code;
        logic                  out_last;
    } code_item_t;

    typedef struct packed {
        logic accept;
        logic probe_next;
        logic resolve;
        logic flush;
        logic clear_write;
    } cmd_t;

    typedef struct packed {
        logic have_prefix;
        logic last;
        logic hit;
        logic vacant;
        logic epoch_end;
        logic sweep_end;
    } sts_t;

endpackage

FILE: src/lzwc_ctrl.sv
module lzwc_ctrl
    import lzwc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic valid,
    input  logic last_byte,
    input  logic queue_room,
    input  sts_t sts,
    output logic stall,
    output cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_FLUSH
    } state_t;

    state_t state_reg, state_next;
    logic   stall_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_write = 1'b1;
                if (sts.sweep_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (valid)
                begin
                    cmd.accept = 1'b1;
                    if (!sts.have_prefix)
                    begin
                        state_next = last_byte ? ST_FLUSH : ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_LOOK;
                    end
                end
            end
            ST_LOOK:
            begin
                if (sts.hit || (sts.vacant && queue_room))
                begin
                    cmd.resolve = 1'b1;
                    state_next  = sts.last ? ST_FLUSH : ST_IDLE;
                end
                else if (!sts.vacant)
                begin
                    cmd.probe_next = 1'b1;
                end
            end
            ST_FLUSH:
            begin
                if (queue_room)
                begin
                    cmd.flush  = 1'b1;
                    state_next = sts.epoch_end ? ST_CLEAR : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            stall_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            stall_reg <= (state_next != ST_IDLE);
        end
    end

    assign stall = stall_reg;

endmodule

FILE: src/lzwc_datapath.sv
module lzwc_datapath
    import lzwc_pkg::*;
#(
    parameter int CODE_BITS = 12
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  byte_item_t item,
    input  cmd_t       cmd,
    output sts_t       sts,
    output logic       push,
    output code_item_t push_item
);

    localparam int KEY_W = CODE_BITS + 8;
    localparam int SLOTS = 1 << CODE_BITS;

    typedef struct packed {
        logic [EPOCH_BITS-1:0] tag;
        logic [KEY_W-1:0]      key;
        logic [CODE_BITS-1:0]  code;
    } slot_t;

    slot_t mem [SLOTS];
    slot_t rdata_reg;
    slot_t wdata;

    logic [CODE_BITS-1:0]  prefix_reg, prefix_next;
    logic [CODE_BITS-1:0]  addr_reg, addr_next;
    logic [CODE_BITS-1:0]  hash_addr;
    logic                  have_prefix_reg, have_prefix_next;
    logic [CODE_BITS:0]    free_reg, free_next;
    logic [EPOCH_BITS-1:0] epoch_reg, epoch_next;
    logic [7:0]            byte_reg;
    logic                  last_reg;
    logic                  rd_en, wr_en, hit, vacant, full;
    logic [CODE_BITS+OUT_CODE_W-1:0] code_wide;

    assign hash_addr = {item.data_byte, {(CODE_BITS-8){1'b0}}} ^ prefix_reg;
    assign vacant    = (rdata_reg.tag != epoch_reg);
    assign hit       = !vacant && (rdata_reg.key == {prefix_reg, byte_reg});
    assign full      = free_reg[CODE_BITS];

    always_comb
    begin
        prefix_next      = prefix_reg;
        addr_next        = addr_reg;
        have_prefix_next = have_prefix_reg;
        free_next        = free_reg;
        epoch_next       = epoch_reg;
        rd_en            = 1'b0;
        wr_en            = 1'b0;
        wdata.tag        = epoch_reg;
        wdata.key        = {prefix_reg, byte_reg};
        wdata.code       = free_reg[CODE_BITS-1:0];

        if (cmd.accept)
        begin
            if (have_prefix_reg)
            begin
                rd_en     = 1'b1;
                addr_next = hash_addr;
            end
            else
            begin
                prefix_next      = {{(CODE_BITS-8){1'b0}}, item.data_byte};
                have_prefix_next = 1'b1;
            end
        end

        if (cmd.probe_next)
        begin
            rd_en     = 1'b1;
            addr_next = addr_reg + 1'b1;
        end

        if (cmd.resolve)
        begin
            if (hit)
            begin
                prefix_next = rdata_reg.code;
            end
            else
            begin
                if (!full)
                begin
                    wr_en     = 1'b1;
                    free_next = free_reg + 1'b1;
                end
                prefix_next = {{(CODE_BITS-8){1'b0}}, byte_reg};
            end
        end

        if (cmd.flush)
        begin
            prefix_next      = '0;
            have_prefix_next = 1'b0;
            free_next        = (CODE_BITS+1)'(LITERAL_CODES);
            epoch_next       = epoch_reg + 1'b1;
            // a following sweep starts at slot 0
            addr_next        = '0;
        end

        if (cmd.clear_write)
        begin
            wr_en     = 1'b1;
            wdata     = '0;
            addr_next = addr_reg + 1'b1;
            if (addr_reg == '1)
            begin
                epoch_next = EPOCH_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_reg      <= '0;
            addr_reg        <= '0;
            have_prefix_reg <= 1'b0;
            free_reg        <= (CODE_BITS+1)'(LITERAL_CODES);
            epoch_reg       <= '0;
        end
        else
        begin
            prefix_reg      <= prefix_next;
            addr_reg        <= addr_next;
            have_prefix_reg <= have_prefix_next;
            free_reg        <= free_next;
            epoch_reg       <= epoch_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            byte_reg <= item.data_byte;
            last_reg <= item.last_byte;
        end
    end

    // single-port table: reads and writes never share a cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr_reg] <= wdata;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[addr_next];
        end
    end

    assign code_wide          = {{OUT_CODE_W{1'b0}}, prefix_reg};
    assign push               = (cmd.resolve && !hit) || cmd.flush;
    assign push_item.out_code = code_wide[OUT_CODE_W-1:0];
    assign push_item.out_last = cmd.flush;

    assign sts.have_prefix = have_prefix_reg;
    assign sts.last        = last_reg;
    assign sts.hit         = hit;
    assign sts.vacant      = vacant;
    assign sts.epoch_end   = (epoch_reg == '1);
    assign sts.sweep_end   = (addr_reg == '1);

endmodule

FILE: src/lzwc_outq.sv
module lzwc_outq
    import lzwc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  code_item_t push_item,
    output logic       room,
    output logic       valid,
    input  logic       stall,
    output code_item_t item
);

    code_item_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign valid = (count_reg != 2'd0);
    assign room  = (count_reg != 2'd2);
    assign pop   = valid && !stall;
    assign item  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: src/lzw_byte_compressor_unit.sv
// Per byte: the first byte of a message only loads the prefix, with no table lookup; each
// later byte reads the slot at its hash, then one further slot per occupied slot passed (one
// table read per cycle on the single-port dictionary). A last byte adds the flush code.
// Codes made by a lookup or flush go through a two-entry output queue to code_valid/code_item.
// Reset clears control state, then a sweep clears all 2^CODE_BITS table slots with byte_stall
// high; the same sweep follows every 63rd message.
`include "lzw_byte_compressor_unit_macros.svh"

module lzw_byte_compressor_unit
    import lzwc_pkg::*;
#(
    parameter int CODE_BITS = 12
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  byte_item_t byte_item,
    output logic       code_valid,
    input  logic       code_stall,
    output code_item_t code_item
);

    cmd_t       cmd;
    sts_t       sts;
    logic       push;
    logic       room;
    code_item_t push_item;

    lzwc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .valid      (byte_valid),
        .last_byte  (byte_item.last_byte),
        .queue_room (room),
        .sts        (sts),
        .stall      (byte_stall),
        .cmd        (cmd)
    );

    lzwc_datapath #(
        .CODE_BITS (CODE_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (byte_item),
        .cmd       (cmd),
        .sts       (sts),
        .push      (push),
        .push_item (push_item)
    );

    lzwc_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .room      (room),
        .valid     (code_valid),
        .stall     (code_stall),
        .item      (code_item)
    );

    `LZWC_ASSERT_ALWAYS(a_push_has_room, clk, rst_n, !push || room)
    `LZWC_ASSERT_IMPL(a_ready_is_quiet, clk, rst_n, !byte_stall, !(cmd.probe_next || cmd.resolve || cmd.flush || cmd.clear_write))
    `LZWC_ASSERT_NEXT(a_flush_ends_message, clk, rst_n, cmd.flush, !sts.have_prefix)

endmodule
